>>> rtl/text_console_writer_unit_defines.svh
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// Package with the request and result types and the fixed codes of the console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W = 4;

    localparam logic [OPCODE_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUT_AT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd3;

    localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] ERR_CODE   = 8'h45;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 4'd1;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAR_W-1:0]   character;
        logic [ATTR_W-1:0]   attribute;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    column;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              scrolled;
        logic              range_error;
        logic [CHAR_W-1:0] read_character;
        logic [ATTR_W-1:0] read_attribute;
    } t_out_item;

endpackage

>>> rtl/tcw_cell_store.sv
// Character/attribute cell memory with one write port and one registered read port.
`timescale 1ns / 1ps
module tcw_cell_store #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] o_rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/text_console_writer_unit.sv
// Top level of the text-mode console writer: sequencer, cursor, config and result register.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_ready o_out_item (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A scroll moves the rows up by one: one shared address counter walks the
// buffer, with a read state and a write state per moved cell on the two memory ports.
// After reset the buffer is zeroed while o_in_ready stays low.
// A finished result waits in the output register while the next request is accepted.
`timescale 1ns / 1ps
`include "text_console_writer_unit_defines.svh"
module text_console_writer_unit #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tcw_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tcw_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL_A = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY_A = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE_A = ADDR_W'(CELLS - COLS);
    localparam logic [ROW_W:0]    ROWS_R      = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0]    COLS_C      = (COL_W + 1)'(COLS);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_READ   = 4'd4;
    localparam logic [3:0] S_RDATA  = 4'd5;
    localparam logic [3:0] S_SCR_RD = 4'd6;
    localparam logic [3:0] S_SCR_WR = 4'd7;
    localparam logic [3:0] S_ZERO   = 4'd8;
    localparam logic [3:0] S_FILL   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]        r_state, n_state;
    t_in_item          r_in, n_in;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ROW_W-1:0]  r_tr, n_tr;
    logic [COL_W-1:0]  r_tc, n_tc;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ADDR_W-1:0] r_cur_addr, n_cur_addr;
    logic              r_scrolled, n_scrolled;
    logic              r_rerr, n_rerr;
    logic [CHAR_W-1:0] r_rch, n_rch;
    logic [ATTR_W-1:0] r_rattr, n_rattr;
    logic [ATTR_W-1:0] r_def_attr, r_err_attr;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;

    logic              in_range;
    logic [ATTR_W-1:0] put_attr;
    logic              is_nl;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              adv_row;
    logic              do_scroll;

    tcw_cell_store #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_range  = ({1'b0, r_in.row} < ROWS_R) && ({1'b0, r_in.column} < COLS_C);
    assign put_attr  = (r_in.attribute == '0) ? r_def_attr : r_in.attribute;
    assign is_nl     = (r_in.character == NL_CODE);
    assign col_inc   = {1'b0, r_tc} + 1'b1;
    assign row_inc   = {1'b0, r_tr} + 1'b1;
    assign adv_row   = is_nl || (col_inc == COLS_C);
    assign do_scroll = adv_row && (row_inc == ROWS_R);

    // The scroll copy reads one row ahead of the cell it writes.
    assign rd_addr = (r_state == S_SCR_RD) ? ADDR_W'(r_ptr + COLS_A) : r_addr;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_ptr       = r_ptr;
        n_addr      = r_addr;
        n_tr        = r_tr;
        n_tc        = r_tc;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_cur_addr  = r_cur_addr;
        n_scrolled  = r_scrolled;
        n_rerr      = r_rerr;
        n_rch       = r_rch;
        n_rattr     = r_rattr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        wr_en       = 1'b0;
        wr_addr     = r_ptr;
        wr_data     = '0;

        unique case (r_state)
            S_INIT: begin
                wr_en = 1'b1;
                n_ptr = ADDR_W'(r_ptr + 1'b1);
                if (r_ptr == LAST_CELL_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in       = i_in_item;
                    n_scrolled = 1'b0;
                    n_rerr     = 1'b0;
                    n_rch      = '0;
                    n_rattr    = '0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_in.opcode == OP_CLEAR) begin
                    n_ptr      = '0;
                    n_cur_row  = '0;
                    n_cur_col  = '0;
                    n_cur_addr = '0;
                    n_state    = S_FILL;
                end else if (r_in.opcode == OP_PUT) begin
                    n_addr  = r_cur_addr;
                    n_tr    = r_cur_row;
                    n_tc    = r_cur_col;
                    n_state = S_PUT;
                end else if (!in_range) begin
                    wr_en   = 1'b1;
                    wr_addr = LAST_CELL_A;
                    wr_data = {r_err_attr, ERR_CODE};
                    n_rerr  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_addr  = ADDR_W'(32'(r_in.row) * COLS + 32'(r_in.column));
                    n_tr    = r_in.row;
                    n_tc    = r_in.column;
                    n_state = (r_in.opcode == OP_PUT_AT) ? S_PUT : S_READ;
                end
            end
            S_PUT: begin
                if (!is_nl) begin
                    wr_en   = 1'b1;
                    wr_addr = r_addr;
                    wr_data = {put_attr, r_in.character};
                end
                n_cur_col = adv_row ? '0 : col_inc[COL_W-1:0];
                if (do_scroll) begin
                    n_cur_row  = LAST_ROW;
                    n_cur_addr = LAST_BASE_A;
                    n_scrolled = 1'b1;
                    n_ptr      = '0;
                    n_state    = S_SCR_RD;
                end else begin
                    n_cur_row  = adv_row ? row_inc[ROW_W-1:0] : r_tr;
                    n_cur_addr = is_nl ? ADDR_W'(r_addr + COLS_A - ADDR_W'(r_tc))
                                       : ADDR_W'(r_addr + 1'b1);
                    n_state    = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_rch   = rd_data[CHAR_W-1:0];
                n_rattr = rd_data[CELL_W-1:CHAR_W];
                n_state = S_DONE;
            end
            S_SCR_RD: begin
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                n_ptr   = ADDR_W'(r_ptr + 1'b1);
                n_state = (r_ptr == LAST_COPY_A) ? S_ZERO : S_SCR_RD;
            end
            S_ZERO: begin
                wr_en = 1'b1;
                n_ptr = ADDR_W'(r_ptr + 1'b1);
                if (r_ptr == LAST_CELL_A) begin
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                wr_en   = 1'b1;
                wr_data = {r_def_attr, SPACE_CODE};
                n_ptr   = ADDR_W'(r_ptr + 1'b1);
                if (r_ptr == LAST_CELL_A) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_item.cursor_row      = r_cur_row;
                    n_out_item.cursor_column   = r_cur_col;
                    n_out_item.scrolled        = r_scrolled;
                    n_out_item.range_error     = r_rerr;
                    n_out_item.read_character  = r_rch;
                    n_out_item.read_attribute  = r_rattr;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_cur_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_cur_addr  <= n_cur_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_addr     <= n_addr;
        r_tr       <= n_tr;
        r_tc       <= n_tc;
        r_scrolled <= n_scrolled;
        r_rerr     <= n_rerr;
        r_rch      <= n_rch;
        r_rattr    <= n_rattr;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_attr <= DEFAULT_ATTR_RST;
            r_err_attr <= ERROR_ATTR_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DEFAULT_ATTR) begin
                r_def_attr <= i_cfg_data;
            end else if (i_cfg_index == CFG_ERROR_ATTR) begin
                r_err_attr <= i_cfg_data;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    `TCW_ASSERT_NOW(a_cursor_bounds, 1'b1, ({1'b0, r_cur_row} < ROWS_R) && ({1'b0, r_cur_col} < COLS_C), "cursor left the screen")
    `TCW_ASSERT_NEXT(a_accept_decodes, i_in_valid && o_in_ready, r_state == S_DECODE, "accepted request not decoded")
    `TCW_ASSERT_NOW(a_scroll_last_row, o_out_valid && o_out_item.scrolled, o_out_item.cursor_row == LAST_ROW, "scroll left cursor off the last row")
    `TCW_ASSERT_NOW(a_error_no_read, o_out_valid && o_out_item.range_error, (o_out_item.read_character == '0) && (o_out_item.read_attribute == '0) && !o_out_item.scrolled, "range error with read data or scroll")

endmodule
